@@ hdl/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the LIFO stack with search
// Store geometry, operation and status codes, and scan unit interface.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int OCC_W  = 7;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;

	typedef enum logic [2:0] {
		ST_PUSHED    = 3'd0,
		ST_POPPED    = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_FOUND     = 3'd4,
		ST_NOTFOUND  = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] key;
		logic [CNT_W-1:0]  limit;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_rsp_t;

endpackage

@@ hdl/lss_store.sv @@
// ----------------------------------------------------------------------------
// lss_store: entry store of the stack
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lss_store (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [lss_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [lss_pkg::WORD_W-1:0]   wr_data,
	input  logic                         rd_en,
	input  logic [lss_pkg::ADDR_W-1:0]   rd_addr,
	output logic [lss_pkg::WORD_W-1:0]   rd_data
);

	logic [lss_pkg::WORD_W-1:0] mem_q [lss_pkg::DEPTH];
	logic [lss_pkg::WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/lss_scan.sv @@
// ----------------------------------------------------------------------------
// lss_scan: membership scan unit
// Walks the store from the bottom, one entry a cycle, through a single
// comparator; stops at the first match or after the top entry.
// ----------------------------------------------------------------------------
module lss_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lss_pkg::scan_req_t           req,
	input  logic [lss_pkg::WORD_W-1:0]   rd_data,
	output logic                         rd_en,
	output logic [lss_pkg::ADDR_W-1:0]   rd_addr,
	output lss_pkg::scan_rsp_t           rsp
);

	logic [lss_pkg::WORD_W-1:0] key_q;
	logic [lss_pkg::CNT_W-1:0]  limit_q;
	logic [lss_pkg::CNT_W-1:0]  idx_q;
	logic                       pend_q;
	logic                       match;
	logic                       last;
	logic                       done;

	// pend_q: a read issued last cycle has its data on rd_data now
	assign match = pend_q && (rd_data == key_q);
	assign last  = (idx_q == limit_q);
	assign done  = pend_q && (match || last);

	assign rd_en   = req.start || (pend_q && !done);
	assign rd_addr = req.start ? '0 : idx_q[lss_pkg::ADDR_W-1:0];

	assign rsp.done = done;
	assign rsp.hit  = match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else if (req.start) begin
			pend_q <= 1'b1;
			idx_q  <= lss_pkg::CNT_W'(1);
		end else if (pend_q) begin
			if (done) begin
				pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q + lss_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q   <= req.key;
			limit_q <= req.limit;
		end
	end

endmodule

@@ hdl/lifo_stack_with_search.sv @@
// Push, overflow, underflow and empty search go from the accepted request
// straight to the result state; a pop first passes through one store read.
// A search compares entries from the bottom until the first match or the
// top entry, through the single store read port feeding one comparator.
// One request at a time; the next is taken once the result is registered.
// Reset clears the entry count; store contents stay undefined, no clear pass.
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack with membership search
// Sequencer, entry count and result register around the store and scan unit.
// ----------------------------------------------------------------------------
module lifo_stack_with_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         op,
	input  logic signed [lss_pkg::WORD_W-1:0]  value,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [2:0]                         status,
	output logic signed [lss_pkg::WORD_W-1:0]  popped_value,
	output logic [lss_pkg::OCC_W-1:0]          occupancy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_RESULT
	} state_t;

	state_t                       state_q;
	logic [lss_pkg::CNT_W-1:0]    count_q;
	lss_pkg::status_t             res_status_q;
	logic [lss_pkg::WORD_W-1:0]   res_pop_q;
	logic                         res_valid_q;
	lss_pkg::status_t             out_status_q;
	logic [lss_pkg::WORD_W-1:0]   out_pop_q;
	logic [lss_pkg::OCC_W-1:0]    out_occ_q;

	logic                         accept;
	logic                         is_empty;
	logic                         is_full;
	logic                         wr_en;
	logic                         pop_rd;
	logic [lss_pkg::ADDR_W-1:0]   top_addr;
	logic [lss_pkg::CNT_W-1:0]    top_idx;
	logic                         mem_rd_en;
	logic [lss_pkg::ADDR_W-1:0]   mem_rd_addr;
	logic [lss_pkg::WORD_W-1:0]   mem_rd_data;
	logic                         scan_rd_en;
	logic [lss_pkg::ADDR_W-1:0]   scan_rd_addr;
	lss_pkg::scan_req_t           scan_req;
	lss_pkg::scan_rsp_t           scan_rsp;
	logic                         load;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q >= lss_pkg::CNT_W'(lss_pkg::DEPTH));
	assign top_idx   = count_q - lss_pkg::CNT_W'(1);
	assign top_addr  = top_idx[lss_pkg::ADDR_W-1:0];

	assign wr_en  = accept && (op == lss_pkg::OP_PUSH) && !is_full;
	assign pop_rd = accept && (op == lss_pkg::OP_POP) && !is_empty;

	assign scan_req.start = accept && (op != lss_pkg::OP_PUSH) && (op != lss_pkg::OP_POP)
		&& !is_empty;
	assign scan_req.key   = value;
	assign scan_req.limit = count_q;

	assign mem_rd_en   = pop_rd || scan_rd_en;
	assign mem_rd_addr = pop_rd ? top_addr : scan_rd_addr;

	// hand the result over when the output register is free or being drained
	assign load = (state_q == S_RESULT) && (!res_valid_q || !res_stall);

	lss_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[lss_pkg::ADDR_W-1:0]),
		.wr_data (value),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	lss_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (scan_req),
		.rd_data (mem_rd_data),
		.rd_en   (scan_rd_en),
		.rd_addr (scan_rd_addr),
		.rsp     (scan_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_pop_q <= '0;
						unique case (op)
							lss_pkg::OP_PUSH: begin
								if (is_full) begin
									res_status_q <= lss_pkg::ST_OVERFLOW;
								end else begin
									count_q      <= count_q + lss_pkg::CNT_W'(1);
									res_status_q <= lss_pkg::ST_PUSHED;
								end
								state_q <= S_RESULT;
							end
							lss_pkg::OP_POP: begin
								if (is_empty) begin
									res_status_q <= lss_pkg::ST_UNDERFLOW;
									state_q      <= S_RESULT;
								end else begin
									count_q <= top_idx;
									state_q <= S_POP;
								end
							end
							default: begin
								if (is_empty) begin
									res_status_q <= lss_pkg::ST_EMPTY;
									state_q      <= S_RESULT;
								end else begin
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_POP: begin
					res_pop_q    <= mem_rd_data;
					res_status_q <= lss_pkg::ST_POPPED;
					state_q      <= S_RESULT;
				end
				S_SCAN: begin
					if (scan_rsp.done) begin
						res_status_q <= scan_rsp.hit ? lss_pkg::ST_FOUND : lss_pkg::ST_NOTFOUND;
						state_q      <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (load) begin
						out_status_q <= res_status_q;
						out_pop_q    <= res_pop_q;
						out_occ_q    <= lss_pkg::OCC_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = out_status_q;
	assign popped_value = out_pop_q;
	assign occupancy    = out_occ_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request taken while block reported idle after accept");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lss_pkg::CNT_W'(lss_pkg::DEPTH))
		else $error("entry count beyond store depth");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_valid)
		else $error("loaded result not presented");

	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == lss_pkg::ST_FOUND || status == lss_pkg::ST_NOTFOUND
		|| status == lss_pkg::ST_PUSHED) |-> occupancy != '0)
		else $error("search or push result reports an empty stack");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == lss_pkg::ST_EMPTY || status == lss_pkg::ST_UNDERFLOW)
		|-> occupancy == '0)
		else $error("empty or underflow result with entries held");

endmodule
